FILE: sv/bba_pkg.sv
package bba_pkg;

  localparam int BLOCK_COUNT = 1024;

  // The bitmap is kept in 32-bit words, one memory row per word.
  localparam int WORD_W    = 32;
  localparam int OFF_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
  localparam int ROW_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BLK_W     = $clog2(BLOCK_COUNT);

  localparam int IDX_W    = 16;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 10;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic              we;
    logic [ROW_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ROW_W-1:0]  raddr;
  } bba_mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GRANT_W-1:0]  grant;
  } bba_res_t;

  // Bits of a row that stand for real blocks; the tail of the last row does not.
  function automatic logic [WORD_W-1:0] row_mask(input logic [ROW_W-1:0] row);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      m[b] = ((int'(row) * WORD_W + b) < BLOCK_COUNT);
    end
    return m;
  endfunction

  // Position of the lowest set bit; zero when no bit is set.
  function automatic logic [OFF_W-1:0] first_set(input logic [WORD_W-1:0] v);
    logic [OFF_W-1:0] pos;
    logic             found;
    pos   = '0;
    found = 1'b0;
    for (int b = 0; b < WORD_W; b++) begin
      if (v[b] && !found) begin
        pos   = OFF_W'(b);
        found = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

FILE: sv/block_bitmap_allocator_top.sv
// First-fit block allocator over a 1024-entry occupancy bitmap held in a
// 32 x 32-bit synchronous RAM with one read and one write port. One item is
// handled at a time. A release first reads its bitmap word before its result
// is passed on, while an allocate on a full map or a release out of range
// goes to the result without a RAM read. An allocate grants the held lowest
// free block and then reads further RAM words, one at a time through the
// single read port of the bitmap RAM, to find the next free block after it.
// The result waits in the controller until the output register is free; the
// next request can be taken in the same cycle as the result becomes valid.
// Reset is immediate: per-row valid bits make every block read as free, so no
// clearing pass follows reset. The result sits in an output register, so a
// new request can be taken while the previous result waits.
module block_bitmap_allocator_top
  import bba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                op_i,
  input  logic [IDX_W-1:0]    block_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [GRANT_W-1:0]  granted_block_o
);

  bba_mem_req_t      mem_req;
  logic [WORD_W-1:0] mem_rdata;
  bba_res_t          res;
  logic              push;
  logic              out_free;

  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [GRANT_W-1:0]  grant_q;

  bba_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .block_index_i (block_index_i),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata),
    .res_o         (res),
    .push_o        (push),
    .out_free_i    (out_free)
  );

  bba_bitmap u_bitmap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      status_q <= res.status;
      grant_q  <= res.grant;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_block_o = grant_q;

endmodule

FILE: sv/bba_bitmap.sv
module bba_bitmap
  import bba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bba_mem_req_t      req_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0]    mem_q [NUM_WORDS];
  logic [NUM_WORDS-1:0] row_vld_q;
  logic [WORD_W-1:0]    rdata_q;
  logic                 rvld_q;

  // A row that was never written since reset reads as all free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= row_vld_q[req_i.raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

FILE: sv/bba_ctrl.sv
module bba_ctrl
  import bba_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              op_i,
  input  logic [IDX_W-1:0]  block_index_i,
  output bba_mem_req_t      mem_req_o,
  input  logic [WORD_W-1:0] mem_rdata_i,
  output bba_res_t          res_o,
  output logic              push_o,
  input  logic              out_free_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACHK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RCHK = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [BLK_W-1:0]    idx_q, idx_d;
  logic [BLK_W-1:0]    grant_q, grant_d;
  logic [BLK_W-1:0]    hint_q, hint_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic                full_q, full_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic [BLK_W-1:0]  in_blk;
  logic              in_range;
  logic [OFF_W-1:0]  g_off;
  logic [OFF_W-1:0]  i_off;
  logic [WORD_W-1:0] lim;
  logic [WORD_W-1:0] above;
  logic [WORD_W-1:0] set_word;
  logic [WORD_W-1:0] clr_word;
  logic [WORD_W-1:0] a_cand;
  logic [WORD_W-1:0] s_cand;
  logic              last_row;
  logic [ROW_W-1:0]  next_row;

  assign in_blk   = block_index_i[BLK_W-1:0];
  assign in_range = ({1'b0, block_index_i} < (IDX_W+1)'(BLOCK_COUNT));
  assign g_off    = OFF_W'(grant_q);
  assign i_off    = OFF_W'(idx_q);
  assign lim      = row_mask(row_q);
  assign above    = ({WORD_W{1'b1}} << g_off) << 1;
  assign set_word = mem_rdata_i | (WORD_W'(1) << g_off);
  assign clr_word = mem_rdata_i & ~(WORD_W'(1) << i_off);
  assign a_cand   = ~set_word & above & lim;
  assign s_cand   = ~mem_rdata_i & lim;
  assign last_row = (row_q == ROW_W'(NUM_WORDS - 1));
  assign next_row = ROW_W'(row_q + 1'b1);

  assign in_ready_o   = (state_q == S_IDLE);
  assign res_o.status = status_q;
  assign res_o.grant  = GRANT_W'(grant_q);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    grant_d   = grant_q;
    hint_d    = hint_q;
    row_d     = row_q;
    full_d    = full_q;
    status_d  = status_q;
    mem_req_o = '0;
    push_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_ALLOC) begin
            if (full_q) begin
              status_d = ST_NO_FREE;
              grant_d  = '0;
              state_d  = S_PUSH;
            end else begin
              grant_d         = hint_q;
              row_d           = ROW_W'(hint_q >> OFF_W);
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = ROW_W'(hint_q >> OFF_W);
              state_d         = S_ACHK;
            end
          end else begin
            grant_d = '0;
            if (!in_range) begin
              status_d = ST_RANGE;
              state_d  = S_PUSH;
            end else begin
              idx_d           = in_blk;
              row_d           = ROW_W'(in_blk >> OFF_W);
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = ROW_W'(in_blk >> OFF_W);
              state_d         = S_RCHK;
            end
          end
        end
      end
      S_ACHK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = row_q;
        mem_req_o.wdata = set_word;
        status_d        = ST_OK;
        if (|a_cand) begin
          hint_d  = BLK_W'({row_q, first_set(a_cand)});
          state_d = S_PUSH;
        end else if (last_row) begin
          full_d  = 1'b1;
          state_d = S_PUSH;
        end else begin
          row_d           = next_row;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = next_row;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (|s_cand) begin
          hint_d  = BLK_W'({row_q, first_set(s_cand)});
          state_d = S_PUSH;
        end else if (last_row) begin
          full_d  = 1'b1;
          state_d = S_PUSH;
        end else begin
          row_d           = next_row;
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = next_row;
        end
      end
      S_RCHK: begin
        state_d = S_PUSH;
        if (!mem_rdata_i[i_off]) begin
          status_d = ST_NOT_ALLOC;
        end else begin
          status_d        = ST_OK;
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = row_q;
          mem_req_o.wdata = clr_word;
          if (full_q || (idx_q < hint_q)) begin
            hint_d = idx_q;
            full_d = 1'b0;
          end
        end
      end
      S_PUSH: begin
        push_o = out_free_i;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hint_q  <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      full_q  <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    grant_q  <= grant_d;
    row_q    <= row_d;
    status_q <= status_d;
  end

  // The scan never reads back the row it is writing in the same cycle.
  a_no_same_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we && mem_req_o.re) |-> (mem_req_o.waddr != mem_req_o.raddr))
    else $error("bitmap read and write hit the same row");

  a_full_alloc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i && op_i == OP_ALLOC && full_q)
      |=> (state_q == S_PUSH && status_q == ST_NO_FREE))
    else $error("allocate on a full map did not report no free block");

  a_full_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_q) |-> ($past(state_q) == S_ACHK || $past(state_q) == S_SCAN))
    else $error("full flag set outside an allocate scan");

  a_scan_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !full_q)
    else $error("scan running while the map is marked full");

endmodule

FILE: tb/block_bitmap_allocator_checker.sv
module block_bitmap_allocator_checker
  import bba_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                op_i,
  input  logic [IDX_W-1:0]    block_index_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [GRANT_W-1:0]  granted_block_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [BLOCK_COUNT-1:0] occupied;
  logic [BLK_W-1:0]       lowest_free;
  logic                   map_full;
  bba_res_t               awaited_replies[$];
  int                     mismatches;

  // First-fit allocation and release against the shadow bitmap; returns the reply the block owes.
  task automatic allocate_or_release(input logic op, input logic [IDX_W-1:0] idx,
                                     output bba_res_t reply);
    logic [BLK_W-1:0] slot;
    reply.status = ST_OK;
    reply.grant  = '0;
    if (op == OP_ALLOC) begin
      if (map_full) begin
        reply.status = ST_NO_FREE;
      end else begin
        slot           = lowest_free;
        occupied[slot] = 1'b1;
        map_full       = 1'b1;
        for (int b = int'(slot) + 1; b < BLOCK_COUNT; b++) begin
          if (!occupied[b]) begin
            lowest_free = BLK_W'(b);
            map_full    = 1'b0;
            break;
          end
        end
        reply.grant = GRANT_W'(slot);
      end
    end else if (int'(idx) >= BLOCK_COUNT) begin
      reply.status = ST_RANGE;
    end else if (!occupied[idx[BLK_W-1:0]]) begin
      reply.status = ST_NOT_ALLOC;
    end else begin
      slot           = idx[BLK_W-1:0];
      occupied[slot] = 1'b0;
      if (map_full || slot < lowest_free) begin
        lowest_free = slot;
        map_full    = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bba_res_t want;
    if (!rst_ni) begin
      occupied    = '0;
      lowest_free = '0;
      map_full    = 1'b0;
      mismatches  = 0;
      awaited_replies.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        allocate_or_release(op_i, block_index_i, want);
        awaited_replies.push_back(want);
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected result transfer, status %0d granted_block %0d",
                   $realtime, status_i, granted_block_i);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $realtime, want.status, status_i);
            mismatches++;
          end
          if (granted_block_i !== want.grant) begin
            $display("%0t: granted_block mismatch, expected %0d actual %0d",
                     $realtime, want.grant, granted_block_i);
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= awaited_replies.size();
  end

endmodule

FILE: tb/tb_block_bitmap_allocator_top.sv
module tb_block_bitmap_allocator_top;
  import bba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RANDOM_ITEMS   = 105;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                op_i          = OP_ALLOC;
  logic [IDX_W-1:0]    block_index_i = '0;
  logic                out_ready_i   = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [GRANT_W-1:0]  granted_block_o;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  block_bitmap_allocator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .block_index_i   (block_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .granted_block_o (granted_block_o)
  );

  block_bitmap_allocator_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .op_i            (op_i),
    .block_index_i   (block_index_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_i        (status_o),
    .granted_block_i (granted_block_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= (rst_ni && ($urandom_range(99) >= stall_pct));
  end

  // Any transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic issue_request(input logic op, input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    block_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_for_replies();
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic random_requests(input int alloc_pct);
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct) begin
        issue_request(OP_ALLOC, IDX_W'($urandom));
      end else if (pick < 15) begin
        issue_request(OP_RELEASE, IDX_W'($urandom_range(65535, BLOCK_COUNT)));
      end else if (pick < 45) begin
        // Low indexes keep pulling the lowest-free pointer down.
        issue_request(OP_RELEASE, IDX_W'($urandom_range(63, 0)));
      end else begin
        issue_request(OP_RELEASE, IDX_W'($urandom_range(BLOCK_COUNT - 1, 0)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Releases on an empty map, range edges, and simple grant/free sequences.
    issue_request(OP_RELEASE, 16'd0);
    issue_request(OP_RELEASE, IDX_W'(BLOCK_COUNT - 1));
    issue_request(OP_RELEASE, IDX_W'(BLOCK_COUNT));
    issue_request(OP_RELEASE, 16'hFFFF);
    issue_request(OP_ALLOC, 16'hFFFF);
    issue_request(OP_ALLOC, 16'h0000);
    issue_request(OP_ALLOC, 16'hAAAA);
    issue_request(OP_RELEASE, 16'd1);
    issue_request(OP_RELEASE, 16'd1);
    issue_request(OP_ALLOC, 16'h5555);
    issue_request(OP_RELEASE, 16'd0);
    issue_request(OP_RELEASE, 16'd2);
    issue_request(OP_ALLOC, 16'd0);
    issue_request(OP_ALLOC, 16'd0);
    issue_request(OP_ALLOC, 16'd0);
    issue_request(OP_RELEASE, 16'd341);
    issue_request(OP_RELEASE, 16'h5555);
    issue_request(OP_RELEASE, 16'h8000);
    issue_request(OP_RELEASE, 16'h03FF);
    issue_request(OP_ALLOC, 16'd0);

    // More grants and frees around the top, the middle and the bottom of the map.
    issue_request(OP_RELEASE, IDX_W'(BLOCK_COUNT - 1));
    issue_request(OP_ALLOC, 16'd0);
    issue_request(OP_ALLOC, 16'd0);
    issue_request(OP_RELEASE, 16'd500);
    issue_request(OP_RELEASE, 16'd7);
    issue_request(OP_ALLOC, 16'd0);
    issue_request(OP_ALLOC, 16'd0);
    issue_request(OP_ALLOC, 16'd0);
    issue_request(OP_RELEASE, IDX_W'(BLOCK_COUNT - 1));
    issue_request(OP_RELEASE, 16'd0);

    random_requests(50);
    in_valid_i <= 1'b0;
    wait_for_replies();

    idle_pct = 88;
    random_requests(30);
    in_valid_i <= 1'b0;
    wait_for_replies();

    idle_pct = 0;
    stall_pct <= 88;
    random_requests(60);
    in_valid_i <= 1'b0;
    wait_for_replies();

    idle_pct = 33;
    stall_pct <= 33;
    random_requests(50);
    in_valid_i <= 1'b0;
    wait_for_replies();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
